/* hdl/config_key_value_tokenizer_core_assert.svh */
// ---------------------------------------------------------------------------
// config key/value tokenizer assertion macros
// shared property forms for the tokenizer core checks
// ---------------------------------------------------------------------------
`ifndef CONFIG_KEY_VALUE_TOKENIZER_CORE_ASSERT_SVH
`define CONFIG_KEY_VALUE_TOKENIZER_CORE_ASSERT_SVH

// same-cycle implication, quiet while in reset
`define CKVT_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, quiet while in reset
`define CKVT_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/ckvt_pkg.sv */
// ---------------------------------------------------------------------------
// ckvt_pkg
// result item type, kind and error codes and byte classes of the tokenizer
// ---------------------------------------------------------------------------
package ckvt_pkg;

	localparam logic [2:0] KIND_SKIP      = 3'd0;
	localparam logic [2:0] KIND_KEY_BYTE  = 3'd1;
	localparam logic [2:0] KIND_VAL_BYTE  = 3'd2;
	localparam logic [2:0] KIND_KEY_DONE  = 3'd3;
	localparam logic [2:0] KIND_VAL_DONE  = 3'd4;
	localparam logic [2:0] KIND_ERROR     = 3'd5;
	localparam logic [2:0] KIND_END       = 3'd6;

	localparam logic [2:0] ERR_NONE       = 3'd0;
	localparam logic [2:0] ERR_NO_EQUALS  = 3'd0;
	localparam logic [2:0] ERR_KEY_SPACE  = 3'd1;
	localparam logic [2:0] ERR_KEY_LEN    = 3'd2;
	localparam logic [2:0] ERR_NO_VALUE   = 3'd3;
	localparam logic [2:0] ERR_VAL_LEN    = 3'd4;

	localparam logic [0:0] REG_KEY_LIMIT   = 1'b0;
	localparam logic [0:0] REG_VALUE_LIMIT = 1'b1;

	localparam logic [7:0] KEY_LIMIT_RESET   = 8'd32;
	localparam logic [7:0] VALUE_LIMIT_RESET = 8'd255;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_HIGH  = 8'h80;

	typedef struct packed {
		logic [7:0] char_out;
		logic [2:0] kind;
		logic [7:0] token_len;
		logic [2:0] error_code;
		logic       last;
	} res_t;

	// control bytes, space and everything from 0x80 up
	function automatic logic is_ws(logic [7:0] b);
		return (b <= CH_SPACE) || (b >= CH_HIGH);
	endfunction

	// bytes that end a line of text outright
	function automatic logic is_stop(logic [7:0] b);
		return (b == CH_HASH) || (b == CH_NL) || (b == CH_NUL);
	endfunction

	function automatic res_t make_res(logic [7:0] ch, logic [2:0] kind, logic [7:0] len,
		logic [2:0] err, logic last);
		res_t r;
		r.char_out   = ch;
		r.kind       = kind;
		r.token_len  = len;
		r.error_code = err;
		r.last       = last;
		return r;
	endfunction

endpackage

/* hdl/config_key_value_tokenizer_core.sv */
// ---------------------------------------------------------------------------
// config_key_value_tokenizer_core
// byte-wise key=value tokenizer with comment skipping and error reporting
// ---------------------------------------------------------------------------
// Takes one text byte per cycle and tags it as skipped, key byte or value
// byte, reporting key and value completion with the token length and
// flagging malformed lines; after an error bytes are skipped until NUL, and
// NUL ends the text. A byte is classified in the cycle it is accepted and
// its results are registered into a four-entry result queue and read out
// in order. Most bytes give one result; a byte that ends a value, and a NUL
// that causes an error, give two, which leave the queue one at a time. The
// queue accepts a byte whenever at least two entries are free, so with the
// output side always ready the block takes one byte per cycle, except that
// input stalls while the second results drain. The limit registers may only
// be written while no results are pending.
// ---------------------------------------------------------------------------
`include "config_key_value_tokenizer_core_assert.svh"

module config_key_value_tokenizer_core #(
	parameter int LEN_BITS = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [0:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] byte_in,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] char_out,
	output logic [2:0] kind,
	output logic [7:0] token_len,
	output logic [2:0] error_code,
	output logic       last
);

	localparam int CMP_W = (LEN_BITS > 8) ? LEN_BITS : 8;
	localparam int DEPTH = 4;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	typedef enum logic [2:0] {
		PH_SKIP,
		PH_COMMENT,
		PH_KEY,
		PH_VALSKIP,
		PH_VAL,
		PH_ERROR
	} phase_t;

	logic [7:0]          key_limit_q;
	logic [7:0]          value_limit_q;
	phase_t              phase_q;
	logic [LEN_BITS-1:0] len_q;
	logic                seen_q;

	ckvt_pkg::res_t      fifo_q [DEPTH];
	logic [PTR_W-1:0]    wptr_q;
	logic [PTR_W-1:0]    rptr_q;
	logic [CNT_W-1:0]    count_q;

	logic                in_acc;
	logic                out_acc;
	logic [CMP_W-1:0]    len_wide;
	logic [7:0]          len_sat;
	logic [LEN_BITS-1:0] len_bump;

	// do_skip outcome for the current byte, from a freshly restarted state
	ckvt_pkg::res_t      sk_r0;
	logic                sk_two;
	phase_t              sk_phase;
	logic [LEN_BITS-1:0] sk_len;

	ckvt_pkg::res_t      r0;
	ckvt_pkg::res_t      r1;
	logic                two;
	phase_t              phase_d;
	logic [LEN_BITS-1:0] len_d;
	logic                seen_d;

	assign in_acc   = in_valid && in_ready;
	assign out_acc  = out_valid && out_ready;
	assign in_ready = count_q <= CNT_W'(DEPTH - 2);
	assign out_valid = count_q != '0;

	assign char_out   = fifo_q[rptr_q].char_out;
	assign kind       = fifo_q[rptr_q].kind;
	assign token_len  = fifo_q[rptr_q].token_len;
	assign error_code = fifo_q[rptr_q].error_code;
	assign last       = fifo_q[rptr_q].last;

	assign len_wide = CMP_W'(len_q);
	assign len_sat  = (len_wide > CMP_W'(255)) ? 8'hFF : len_wide[7:0];
	assign len_bump = (len_q == '1) ? len_q : len_q + LEN_BITS'(1);

	always_comb begin
		sk_two   = 1'b0;
		sk_phase = PH_SKIP;
		sk_len   = '0;
		sk_r0    = ckvt_pkg::make_res(byte_in, ckvt_pkg::KIND_SKIP, 8'd0,
			ckvt_pkg::ERR_NONE, 1'b1);
		priority if (byte_in == ckvt_pkg::CH_NUL) begin
			sk_r0 = ckvt_pkg::make_res(ckvt_pkg::CH_NUL, ckvt_pkg::KIND_END, 8'd0,
				ckvt_pkg::ERR_NONE, 1'b1);
		end else if (ckvt_pkg::is_ws(byte_in)) begin
			sk_phase = PH_SKIP;
		end else if (byte_in == ckvt_pkg::CH_HASH) begin
			sk_phase = PH_COMMENT;
		end else if (byte_in == ckvt_pkg::CH_EQ) begin
			// empty key
			sk_phase = PH_ERROR;
			sk_r0    = ckvt_pkg::make_res(byte_in, ckvt_pkg::KIND_ERROR, 8'd0,
				ckvt_pkg::ERR_KEY_LEN, 1'b1);
		end else begin
			sk_phase = PH_KEY;
			sk_len   = LEN_BITS'(1);
			sk_r0    = ckvt_pkg::make_res(byte_in, ckvt_pkg::KIND_KEY_BYTE, 8'd0,
				ckvt_pkg::ERR_NONE, 1'b1);
		end
		sk_two = 1'b0;
	end

	always_comb begin
		logic       do_fail;
		logic [2:0] fail_code;
		do_fail   = 1'b0;
		fail_code = ckvt_pkg::ERR_NONE;
		two       = 1'b0;
		phase_d   = phase_q;
		len_d     = len_q;
		seen_d    = seen_q;
		r0        = ckvt_pkg::make_res(byte_in, ckvt_pkg::KIND_SKIP, 8'd0,
			ckvt_pkg::ERR_NONE, 1'b1);
		r1        = ckvt_pkg::make_res(ckvt_pkg::CH_NUL, ckvt_pkg::KIND_END, 8'd0,
			ckvt_pkg::ERR_NONE, 1'b1);
		unique case (phase_q)
			PH_COMMENT: begin
				if (byte_in == ckvt_pkg::CH_NUL) begin
					r0      = r1;
					phase_d = PH_SKIP;
					len_d   = '0;
					seen_d  = 1'b0;
				end else if (byte_in == ckvt_pkg::CH_NL) begin
					phase_d = PH_SKIP;
				end
			end
			PH_KEY: begin
				priority if (byte_in == ckvt_pkg::CH_EQ) begin
					if (len_q == '0 || len_wide >= CMP_W'(key_limit_q)) begin
						do_fail   = 1'b1;
						fail_code = ckvt_pkg::ERR_KEY_LEN;
					end else begin
						r0      = ckvt_pkg::make_res(byte_in, ckvt_pkg::KIND_KEY_DONE,
							len_sat, ckvt_pkg::ERR_NONE, 1'b1);
						phase_d = PH_VALSKIP;
						len_d   = '0;
						seen_d  = 1'b0;
					end
				end else if (ckvt_pkg::is_stop(byte_in)) begin
					do_fail   = 1'b1;
					fail_code = ckvt_pkg::ERR_NO_EQUALS;
				end else if (ckvt_pkg::is_ws(byte_in)) begin
					seen_d = 1'b1;
				end else if (seen_q) begin
					do_fail   = 1'b1;
					fail_code = ckvt_pkg::ERR_KEY_SPACE;
				end else begin
					len_d = len_bump;
					r0    = ckvt_pkg::make_res(byte_in, ckvt_pkg::KIND_KEY_BYTE, 8'd0,
						ckvt_pkg::ERR_NONE, 1'b1);
				end
			end
			PH_VALSKIP: begin
				priority if (ckvt_pkg::is_stop(byte_in)) begin
					do_fail   = 1'b1;
					fail_code = ckvt_pkg::ERR_NO_VALUE;
				end else if (ckvt_pkg::is_ws(byte_in)) begin
					phase_d = PH_VALSKIP;
				end else begin
					phase_d = PH_VAL;
					len_d   = LEN_BITS'(1);
					r0      = ckvt_pkg::make_res(byte_in, ckvt_pkg::KIND_VAL_BYTE, 8'd0,
						ckvt_pkg::ERR_NONE, 1'b1);
				end
			end
			PH_VAL: begin
				if (ckvt_pkg::is_ws(byte_in) || byte_in == ckvt_pkg::CH_HASH) begin
					if (len_wide > CMP_W'(value_limit_q)) begin
						do_fail   = 1'b1;
						fail_code = ckvt_pkg::ERR_VAL_LEN;
					end else begin
						// value done, then the same byte starts the skip phase
						r0      = ckvt_pkg::make_res(byte_in, ckvt_pkg::KIND_VAL_DONE,
							len_sat, ckvt_pkg::ERR_NONE, 1'b0);
						two     = 1'b1;
						r1      = sk_r0;
						phase_d = sk_phase;
						len_d   = sk_len;
						seen_d  = 1'b0;
					end
				end else begin
					len_d = len_bump;
					r0    = ckvt_pkg::make_res(byte_in, ckvt_pkg::KIND_VAL_BYTE, 8'd0,
						ckvt_pkg::ERR_NONE, 1'b1);
				end
			end
			PH_ERROR: begin
				if (byte_in == ckvt_pkg::CH_NUL) begin
					r0      = r1;
					phase_d = PH_SKIP;
					len_d   = '0;
					seen_d  = 1'b0;
				end
			end
			default: begin
				r0      = sk_r0;
				two     = sk_two;
				phase_d = sk_phase;
				len_d   = sk_len;
				seen_d  = 1'b0;
			end
		endcase
		if (do_fail) begin
			// a NUL that fails also closes the text
			r0      = ckvt_pkg::make_res(byte_in, ckvt_pkg::KIND_ERROR, 8'd0, fail_code,
				byte_in != ckvt_pkg::CH_NUL);
			two     = byte_in == ckvt_pkg::CH_NUL;
			r1      = ckvt_pkg::make_res(ckvt_pkg::CH_NUL, ckvt_pkg::KIND_END, 8'd0,
				ckvt_pkg::ERR_NONE, 1'b1);
			phase_d = (byte_in == ckvt_pkg::CH_NUL) ? PH_SKIP : PH_ERROR;
			len_d   = '0;
			seen_d  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_limit_q   <= ckvt_pkg::KEY_LIMIT_RESET;
			value_limit_q <= ckvt_pkg::VALUE_LIMIT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ckvt_pkg::REG_KEY_LIMIT:   key_limit_q   <= cfg_data;
				ckvt_pkg::REG_VALUE_LIMIT: value_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SKIP;
			len_q   <= '0;
			seen_q  <= 1'b0;
		end else if (in_acc) begin
			phase_q <= phase_d;
			len_q   <= len_d;
			seen_q  <= seen_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (in_acc) begin
				wptr_q <= two ? wptr_q + PTR_W'(2) : wptr_q + PTR_W'(1);
			end
			if (out_acc) begin
				rptr_q <= rptr_q + PTR_W'(1);
			end
			count_q <= count_q
				+ (in_acc ? (two ? CNT_W'(2) : CNT_W'(1)) : CNT_W'(0))
				- (out_acc ? CNT_W'(1) : CNT_W'(0));
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			fifo_q[wptr_q] <= r0;
			if (two) begin
				fifo_q[wptr_q + PTR_W'(1)] <= r1;
			end
		end
	end

	`CKVT_ASSERT_NOW(a_queue_bound, 1'b1, count_q <= CNT_W'(DEPTH),
		"result queue overfilled")
	`CKVT_ASSERT_NOW(a_end_clean, out_valid && kind == ckvt_pkg::KIND_END,
		char_out == ckvt_pkg::CH_NUL && token_len == 8'd0 && last,
		"end result carries stray payload")
	`CKVT_ASSERT_NOW(a_err_only, out_valid && kind != ckvt_pkg::KIND_ERROR,
		error_code == ckvt_pkg::ERR_NONE, "error code outside an error result")
	`CKVT_ASSERT_NOW(a_token_len, phase_q == PH_KEY || phase_q == PH_VAL,
		len_q != '0, "token length lost inside a key or value")

endmodule

/* sim/tb.sv */
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for config_key_value_tokenizer_core. Text bytes go in
// through a queue-fed driver, and a clocked monitor predicts the tagged
// results of every accepted byte and checks each result item against the
// oldest prediction. Runs a short directed text, then random key=value lines
// with noise and malformed lines, over several limit settings and idle mixes.
// ---------------------------------------------------------------------------
module tb;

	typedef enum logic [2:0] {
		SCAN_BLANK,
		SCAN_COMMENT,
		SCAN_KEY,
		SCAN_GAP,
		SCAN_VALUE,
		SCAN_DEAD
	} scan_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic [0:0] cfg_index = ckvt_pkg::REG_KEY_LIMIT;
	logic [7:0] cfg_data = 8'h00;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] byte_in = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b1;
	logic [7:0] char_out;
	logic [2:0] kind;
	logic [7:0] token_len;
	logic [2:0] error_code;
	logic       last;

	logic [7:0]     pending_text[$];
	ckvt_pkg::res_t results_due[$];
	ckvt_pkg::res_t step_out[$];
	int             bytes_added = 0;
	int             failures = 0;
	int             send_idle_pct = 0;
	int             recv_stall_pct = 0;

	// predictor state
	scan_t      scan = SCAN_BLANK;
	logic [7:0] tok_count = 8'd0;
	logic       key_gap = 1'b0;
	logic [7:0] key_lim = ckvt_pkg::KEY_LIMIT_RESET;
	logic [7:0] val_lim = ckvt_pkg::VALUE_LIMIT_RESET;

	config_key_value_tokenizer_core u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.byte_in    (byte_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.char_out   (char_out),
		.kind       (kind),
		.token_len  (token_len),
		.error_code (error_code),
		.last       (last)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("tb failed");
		$finish;
	end

	// ------------------------------------------------------------------
	// prediction
	// ------------------------------------------------------------------
	function automatic logic is_blank(input logic [7:0] b);
		return (b <= ckvt_pkg::CH_SPACE) || (b >= ckvt_pkg::CH_HIGH);
	endfunction

	function automatic logic ends_line(input logic [7:0] b);
		return (b == ckvt_pkg::CH_HASH) || (b == ckvt_pkg::CH_NL) ||
			(b == ckvt_pkg::CH_NUL);
	endfunction

	task automatic emit(input logic [7:0] ch, input logic [2:0] k, input logic [7:0] len,
		input logic [2:0] err);
		ckvt_pkg::res_t r;
		r.char_out   = ch;
		r.kind       = k;
		r.token_len  = len;
		r.error_code = err;
		r.last       = 1'b0;
		step_out.push_back(r);
	endtask

	task automatic clear_scan(input scan_t next);
		scan = next;
		tok_count = 8'd0;
		key_gap = 1'b0;
	endtask

	task automatic finish_text();
		emit(ckvt_pkg::CH_NUL, ckvt_pkg::KIND_END, 8'd0, ckvt_pkg::ERR_NONE);
		clear_scan(SCAN_BLANK);
	endtask

	// a NUL that causes an error also ends the text
	task automatic raise_error(input logic [2:0] code, input logic [7:0] b);
		emit(b, ckvt_pkg::KIND_ERROR, 8'd0, code);
		clear_scan(SCAN_DEAD);
		if (b == ckvt_pkg::CH_NUL)
			finish_text();
	endtask

	task automatic count_byte();
		if (tok_count != 8'hFF)
			tok_count++;
	endtask

	task automatic start_line(input logic [7:0] b);
		if (b == ckvt_pkg::CH_NUL) begin
			finish_text();
		end else if (is_blank(b)) begin
			emit(b, ckvt_pkg::KIND_SKIP, 8'd0, ckvt_pkg::ERR_NONE);
		end else if (b == ckvt_pkg::CH_HASH) begin
			scan = SCAN_COMMENT;
			emit(b, ckvt_pkg::KIND_SKIP, 8'd0, ckvt_pkg::ERR_NONE);
		end else if (b == ckvt_pkg::CH_EQ) begin
			raise_error(ckvt_pkg::ERR_KEY_LEN, b);
		end else begin
			scan = SCAN_KEY;
			tok_count = 8'd1;
			key_gap = 1'b0;
			emit(b, ckvt_pkg::KIND_KEY_BYTE, 8'd0, ckvt_pkg::ERR_NONE);
		end
	endtask

	task automatic tokenize_byte(input logic [7:0] b);
		ckvt_pkg::res_t r;
		step_out.delete();
		case (scan)
			SCAN_COMMENT: begin
				if (b == ckvt_pkg::CH_NUL) begin
					finish_text();
				end else begin
					if (b == ckvt_pkg::CH_NL)
						scan = SCAN_BLANK;
					emit(b, ckvt_pkg::KIND_SKIP, 8'd0, ckvt_pkg::ERR_NONE);
				end
			end
			SCAN_KEY: begin
				if (b == ckvt_pkg::CH_EQ) begin
					if (tok_count == 8'd0 || tok_count >= key_lim) begin
						raise_error(ckvt_pkg::ERR_KEY_LEN, b);
					end else begin
						emit(b, ckvt_pkg::KIND_KEY_DONE, tok_count, ckvt_pkg::ERR_NONE);
						clear_scan(SCAN_GAP);
					end
				end else if (ends_line(b)) begin
					raise_error(ckvt_pkg::ERR_NO_EQUALS, b);
				end else if (is_blank(b)) begin
					key_gap = 1'b1;
					emit(b, ckvt_pkg::KIND_SKIP, 8'd0, ckvt_pkg::ERR_NONE);
				end else if (key_gap) begin
					raise_error(ckvt_pkg::ERR_KEY_SPACE, b);
				end else begin
					count_byte();
					emit(b, ckvt_pkg::KIND_KEY_BYTE, 8'd0, ckvt_pkg::ERR_NONE);
				end
			end
			SCAN_GAP: begin
				if (ends_line(b)) begin
					raise_error(ckvt_pkg::ERR_NO_VALUE, b);
				end else if (is_blank(b)) begin
					emit(b, ckvt_pkg::KIND_SKIP, 8'd0, ckvt_pkg::ERR_NONE);
				end else begin
					scan = SCAN_VALUE;
					tok_count = 8'd1;
					emit(b, ckvt_pkg::KIND_VAL_BYTE, 8'd0, ckvt_pkg::ERR_NONE);
				end
			end
			SCAN_VALUE: begin
				if (is_blank(b) || b == ckvt_pkg::CH_HASH) begin
					if (tok_count > val_lim) begin
						raise_error(ckvt_pkg::ERR_VAL_LEN, b);
					end else begin
						// the terminator is then parsed again as a line start
						emit(b, ckvt_pkg::KIND_VAL_DONE, tok_count, ckvt_pkg::ERR_NONE);
						clear_scan(SCAN_BLANK);
						start_line(b);
					end
				end else begin
					count_byte();
					emit(b, ckvt_pkg::KIND_VAL_BYTE, 8'd0, ckvt_pkg::ERR_NONE);
				end
			end
			SCAN_DEAD: begin
				if (b == ckvt_pkg::CH_NUL)
					finish_text();
				else
					emit(b, ckvt_pkg::KIND_SKIP, 8'd0, ckvt_pkg::ERR_NONE);
			end
			default: begin
				scan = SCAN_BLANK;
				start_line(b);
			end
		endcase
		r = step_out.pop_back();
		r.last = 1'b1;
		step_out.push_back(r);
		foreach (step_out[i])
			results_due.push_back(step_out[i]);
	endtask

	task automatic check_field(input string name, input int want, input int seen);
		if (want != seen) begin
			$error("%s: expected %0d, got %0d", name, want, seen);
			failures++;
		end
	endtask

	// ------------------------------------------------------------------
	// driver, receiver and monitor
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && (!in_valid || in_ready)) begin
			if (pending_text.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				byte_in <= pending_text.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin : monitor
		ckvt_pkg::res_t want;
		if (arst_n) begin
			if (cfg_we) begin
				if (cfg_index == ckvt_pkg::REG_KEY_LIMIT)
					key_lim = cfg_data;
				else
					val_lim = cfg_data;
			end
			if (in_valid && in_ready)
				tokenize_byte(byte_in);
			if (out_valid && out_ready) begin
				if (results_due.size() == 0) begin
					$error("result item with none expected: char_out %0d kind %0d",
						char_out, kind);
					failures++;
				end else begin
					want = results_due.pop_front();
					check_field("char_out", want.char_out, char_out);
					check_field("kind", want.kind, kind);
					check_field("token_len", want.token_len, token_len);
					check_field("error_code", want.error_code, error_code);
					check_field("last", want.last, last);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------
	task automatic add_byte(input logic [7:0] b);
		pending_text.push_back(b);
		bytes_added++;
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i]);
	endtask

	// whitespace that neither ends a line nor ends the text
	function automatic logic [7:0] blank_byte();
		logic [7:0] c;
		if ($urandom_range(1) == 1) begin
			c = 8'($urandom_range(128, 255));
		end else begin
			c = 8'($urandom_range(1, 32));
			if (c == ckvt_pkg::CH_NL)
				c = ckvt_pkg::CH_SPACE;
		end
		return c;
	endfunction

	function automatic logic [7:0] key_char();
		logic [7:0] c;
		do
			c = 8'($urandom_range(8'h21, 8'h7E));
		while (c == ckvt_pkg::CH_EQ || c == ckvt_pkg::CH_HASH);
		return c;
	endfunction

	function automatic logic [7:0] value_char();
		logic [7:0] c;
		do
			c = 8'($urandom_range(8'h21, 8'h7E));
		while (c == ckvt_pkg::CH_HASH);
		return c;
	endfunction

	function automatic logic [7:0] comment_char();
		logic [7:0] c;
		c = 8'($urandom_range(1, 255));
		return (c == ckvt_pkg::CH_NL) ? ckvt_pkg::CH_SPACE : c;
	endfunction

	function automatic logic [7:0] stop_byte();
		case ($urandom_range(2))
			0: return ckvt_pkg::CH_HASH;
			1: return ckvt_pkg::CH_NL;
			default: return ckvt_pkg::CH_NUL;
		endcase
	endfunction

	// lengths mostly short, often right around a small limit
	function automatic int pick_len(input int lim);
		if (lim <= 12 && $urandom_range(1) == 1)
			return $urandom_range((lim > 1) ? lim - 1 : 1, lim + 1);
		return $urandom_range(1, 5);
	endfunction

	task automatic end_value();
		case ($urandom_range(3))
			0: add_byte(ckvt_pkg::CH_NUL);
			1: begin
				add_byte(ckvt_pkg::CH_HASH);
				repeat ($urandom_range(0, 4)) add_byte(comment_char());
				add_byte(ckvt_pkg::CH_NL);
			end
			default: add_byte(($urandom_range(2) == 0) ? ckvt_pkg::CH_NL : blank_byte());
		endcase
	endtask

	// one line of text: mostly well formed, some comments, noise and broken lines
	task automatic add_line(input int klim, input int vlim);
		int   roll;
		int   klen;
		int   vlen;
		logic broken;
		roll = $urandom_range(99);
		broken = 1'b0;
		klen = 1;
		repeat ($urandom_range(0, 2)) add_byte(blank_byte());
		if (roll < 6) begin
			add_byte(ckvt_pkg::CH_HASH);
			repeat ($urandom_range(0, 6)) add_byte(comment_char());
			add_byte(ckvt_pkg::CH_NL);
		end else if (roll < 12) begin
			repeat ($urandom_range(1, 8)) add_byte(8'($urandom_range(0, 255)));
			broken = 1'b1;
		end else begin
			klen = (roll < 15) ? 0 : pick_len(klim);
			repeat (klen) add_byte(key_char());
			if (roll >= 15 && roll < 19) begin
				add_byte(blank_byte());
				add_byte(key_char());
			end
			if ($urandom_range(3) == 0)
				add_byte(blank_byte());
			if (roll >= 19 && roll < 23) begin
				add_byte(stop_byte());
			end else begin
				add_byte(ckvt_pkg::CH_EQ);
				repeat ($urandom_range(0, 2)) add_byte(blank_byte());
				if (roll < 27) begin
					add_byte(stop_byte());
				end else begin
					vlen = pick_len(vlim);
					repeat (vlen) add_byte(value_char());
					end_value();
					broken = (vlen > vlim);
				end
			end
			broken = broken || (roll < 27) || (klen >= klim);
		end
		// bytes after an error are skipped until NUL, so close broken lines
		if (broken || $urandom_range(7) == 0)
			add_byte(ckvt_pkg::CH_NUL);
	endtask

	task automatic write_limits(input logic [7:0] klim, input logic [7:0] vlim);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= ckvt_pkg::REG_KEY_LIMIT;
		cfg_data <= klim;
		@(posedge clk);
		cfg_index <= ckvt_pkg::REG_VALUE_LIMIT;
		cfg_data <= vlim;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_text.size() != 0 || in_valid || results_due.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		int klims[6] = '{3, 1, 255, 0, 8, 2};
		int vlims[6] = '{2, 254, 255, 0, 5, 1};
		int send_pct[6] = '{52, 0, 18, 0, 18, 0};
		int recv_pct[6] = '{0, 52, 18, 0, 18, 52};
		int mark;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// key, trailing blank, value ended by a comment, then a lone '='
		add_text("k =v#\n=");
		add_byte(ckvt_pkg::CH_NUL);
		// blank inside the key
		add_text("a b");
		add_byte(ckvt_pkg::CH_NUL);
		// NUL inside the key and NUL before the value both end the text too
		add_text("x");
		add_byte(ckvt_pkg::CH_NUL);
		add_text("y=");
		add_byte(ckvt_pkg::CH_NUL);
		// high bytes count as whitespace, DEL does not
		add_byte(8'h7F);
		add_byte(ckvt_pkg::CH_EQ);
		add_byte(8'hFF);
		add_byte(8'h21);
		add_byte(ckvt_pkg::CH_HIGH);
		// value ended by NUL
		add_text("z=w");
		add_byte(ckvt_pkg::CH_NUL);
		wait_drained();

		for (int ph = 0; ph < 6; ph++) begin
			write_limits(8'(klims[ph]), 8'(vlims[ph]));
			send_idle_pct = send_pct[ph];
			recv_stall_pct = recv_pct[ph];
			mark = bytes_added;
			if (klims[ph] == 255) begin
				// longest key that fits, and a value past the counter's top
				repeat (254) add_byte(key_char());
				add_byte(ckvt_pkg::CH_EQ);
				add_byte(value_char());
				add_byte(ckvt_pkg::CH_SPACE);
				add_byte(key_char());
				add_byte(ckvt_pkg::CH_EQ);
				repeat (258) add_byte(value_char());
				add_byte(ckvt_pkg::CH_NL);
				mark = bytes_added;
			end
			while (bytes_added - mark < 150)
				add_line(klims[ph], vlims[ph]);
			wait_drained();
		end

		repeat (10) @(posedge clk);
		if (failures == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
